/* design/wsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, codes and saturation helpers for the surface projection fit.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // field widths fixed by the stream format
    localparam int ROW_W    = 3;
    localparam int COL_W    = 8;
    localparam int WORD_W   = 32;
    localparam int SAMP_W   = 32;
    localparam int ACC_W    = 64;
    localparam int RSUM_W   = 48;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 9;
    localparam int CADDR_W  = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    // command carried in tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CADDR_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CADDR_W-1:0] REG_NUM_COEF   = 2'd1;
    localparam logic [CADDR_W-1:0] REG_RET_ICPT   = 2'd2;
    localparam logic [CADDR_W-1:0] REG_FORCE_CTR  = 2'd3;

    // fit status codes
    localparam logic [STAT_W-1:0] ST_FIT    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FLAT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NODATA = 2'd2;

    // window summary handed to the emitter
    typedef struct packed {
        logic                     missing;
        logic                     all_equal;
        logic signed [SAMP_W-1:0] first;
        logic signed [SAMP_W-1:0] centre;
    } t_win_flags;

    // emission mode from the registers
    typedef struct packed {
        logic [ROW_W-1:0] nout;
        logic             force_ctr;
        logic             ret_icpt;
    } t_emit_mode;

    // pipeline end markers from the accumulator
    typedef struct packed {
        logic s1_end;
        logic s2_end;
    } t_pipe_stat;

    function automatic logic signed [ACC_W-1:0] sat65(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] == v[ACC_W-1]) r = v[ACC_W-1:0];
        else if (v[ACC_W]) r = {1'b1, {(ACC_W-1){1'b0}}};
        else r = {1'b0, {(ACC_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat81(input logic signed [80:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[80:ACC_W-1] == {(81-ACC_W+1){1'b0}} || v[80:ACC_W-1] == {(81-ACC_W+1){1'b1}})
            r = v[ACC_W-1:0];
        else if (v[80]) r = {1'b1, {(ACC_W-1){1'b0}}};
        else r = {1'b0, {(ACC_W-1){1'b1}}};
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/wsp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/wsp_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_mac
// Table banks and per-coefficient multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module wsp_mac
    import wsp_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int MAX_COEF   = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [ROW_W-1:0]              i_row,
    input  wire logic [$clog2(MAX_WINDOW)-1:0] i_waddr,
    input  wire logic [WORD_W-1:0]             i_word,
    input  wire logic                          i_samp,
    input  wire logic [$clog2(MAX_WINDOW)-1:0] i_raddr,
    input  wire logic signed [SAMP_W-1:0]      i_z,
    input  wire logic                          i_ok,
    input  wire logic                          i_end,
    output t_pipe_stat                         o_stat,
    output logic                               o_fin,
    output logic [MAX_COEF-1:0][ACC_W-1:0]     o_fin_acc,
    output logic [MAX_COEF-1:0][RSUM_W-1:0]    o_fin_row
);
    localparam int AW = $clog2(MAX_WINDOW);

    logic [MAX_COEF-1:0][WORD_W-1:0] w_rd;
    logic                            r_s1_v, r_s1_ok, r_s1_end;
    logic signed [SAMP_W-1:0]        r_s1_z;
    logic                            r_s2_v, r_s2_ok, r_s2_end;
    logic [MAX_COEF-1:0][ACC_W-1:0]  r_s2_prod;
    logic [MAX_COEF-1:0][WORD_W-1:0] r_s2_t;
    logic [MAX_COEF-1:0][ACC_W-1:0]  r_acc, n_acc;
    logic [MAX_COEF-1:0][RSUM_W-1:0] r_row, n_row;

    // one table bank per coefficient
    for (genvar g = 0; g < MAX_COEF; g++) begin : g_bank
        wsp_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WINDOW)) u_bank (
            .i_clk   (i_clk),
            .i_we    (i_load && (i_row == ROW_W'(g))),
            .i_waddr (i_waddr),
            .i_wdata (i_word),
            .i_raddr (i_raddr),
            .o_rdata (w_rd[g])
        );
    end

    // stage 1: sample alongside table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_end <= 1'b0;
        end else begin
            r_s1_v   <= i_samp;
            r_s1_end <= i_samp && i_end;
        end
        r_s1_z  <= i_z;
        r_s1_ok <= i_ok;
    end

    // stage 2: products registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v   <= 1'b0;
            r_s2_end <= 1'b0;
        end else begin
            r_s2_v   <= r_s1_v;
            r_s2_end <= r_s1_end;
        end
        r_s2_ok <= r_s1_ok;
        for (int j = 0; j < MAX_COEF; j++) begin
            r_s2_prod[j] <= ACC_W'($signed(w_rd[j]) * r_s1_z);
            r_s2_t[j]    <= w_rd[j];
        end
    end

    // saturating accumulate and table row sums
    always_comb begin
        for (int j = 0; j < MAX_COEF; j++) begin
            n_acc[j] = r_s2_ok
                ? sat65($signed({r_acc[j][ACC_W-1], r_acc[j]})
                        + $signed({r_s2_prod[j][ACC_W-1], r_s2_prod[j]}))
                : r_acc[j];
            n_row[j] = r_row[j] + {{(RSUM_W-WORD_W){r_s2_t[j][WORD_W-1]}}, r_s2_t[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_row <= '0;
        end else if (r_s2_v) begin
            if (r_s2_end) begin
                r_acc <= '0;
                r_row <= '0;
            end else begin
                r_acc <= n_acc;
                r_row <= n_row;
            end
        end
    end

    assign o_fin         = r_s2_v && r_s2_end;
    assign o_fin_acc     = n_acc;
    assign o_fin_row     = n_row;
    assign o_stat.s1_end = r_s1_v && r_s1_end;
    assign o_stat.s2_end = r_s2_v && r_s2_end;

    logic unused_aw;
    assign unused_aw = (AW > 0);
endmodule
`default_nettype wire

/* design/wsp_emit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_emit
// Result sequencer: centre correction and one coefficient beat at a time.
// ----------------------------------------------------------------------------
module wsp_emit
    import wsp_pkg::*;
#(
    parameter int MAX_COEF = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fin,
    input  wire logic [MAX_COEF-1:0][ACC_W-1:0]  i_fin_acc,
    input  wire logic [MAX_COEF-1:0][RSUM_W-1:0] i_fin_row,
    input  t_win_flags                         i_flags,
    input  t_emit_mode                         i_mode,
    output logic                               o_busy,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [M_TDATA_W-1:0]               m_axis_tdata,
    output logic                               m_axis_tlast
);
    localparam int CIW = $clog2(MAX_COEF);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MLO  = 6'b000010,
        S_MHI  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DIF  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic [ROW_W-1:0]               r_j;
    logic [MAX_COEF-1:0][ACC_W-1:0]  r_acc;
    logic [MAX_COEF-1:0][RSUM_W-1:0] r_row;
    logic signed [56:0]             r_plo;
    logic signed [55:0]             r_phi;
    logic signed [79:0]             r_prod;
    logic signed [ACC_W-1:0]        r_val, n_val;
    logic [STAT_W-1:0]              r_stat, n_stat;
    logic                           r_last;
    logic [RSUM_W-1:0]              w_row;
    logic signed [ACC_W-1:0]        w_acc;
    logic                           w_last;

    assign w_row  = r_row[r_j[CIW-1:0]];
    assign w_acc  = $signed(r_acc[r_j[CIW-1:0]]);
    assign w_last = (r_j == i_mode.nout - ROW_W'(1));

    // state sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_fin && i_mode.nout != '0) n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_SUM;
            S_SUM:  n_state = S_DIF;
            S_DIF:  n_state = S_OUT;
            S_OUT: begin
                if (m_axis_tready) n_state = r_last ? S_IDLE : S_MLO;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // coefficient value and status
    always_comb begin
        n_val  = '0;
        n_stat = ST_FIT;
        priority if (i_flags.missing) begin
            n_stat = ST_NODATA;
        end else if (i_flags.all_equal) begin
            n_stat = ST_FLAT;
            if (!i_mode.force_ctr && i_mode.ret_icpt && w_last)
                n_val = {{8{i_flags.first[SAMP_W-1]}}, i_flags.first, 24'd0};
        end else if (i_mode.force_ctr) begin
            n_val = sat81({{17{w_acc[ACC_W-1]}}, w_acc} - {r_prod[79], r_prod});
        end else begin
            n_val = w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) r_j <= '0;
            else if (r_state == S_OUT && m_axis_tready) r_j <= r_j + ROW_W'(1);
        end
        // snapshot of the finished window
        if (r_state == S_IDLE && i_fin) begin
            r_acc <= i_fin_acc;
            r_row <= i_fin_row;
        end
        // row sum times centre in two partial products
        if (r_state == S_MLO)
            r_plo <= $signed({1'b0, w_row[23:0]}) * i_flags.centre;
        if (r_state == S_MHI)
            r_phi <= $signed(w_row[RSUM_W-1:24]) * i_flags.centre;
        if (r_state == S_SUM)
            r_prod <= ($signed({{24{r_phi[55]}}, r_phi}) <<< 24)
                      + $signed({{23{r_plo[56]}}, r_plo});
        if (r_state == S_DIF) begin
            r_val  <= n_val;
            r_stat <= n_stat;
            r_last <= w_last;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    // tdata: coef_index[2:0], coef_value[66:3], fit_status[68:67], zero pad
    assign m_axis_tdata  = {3'd0, r_stat, r_val, r_j};
    assign m_axis_tlast  = r_last;
endmodule
`default_nettype wire

/* design/window_surface_projection_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_surface_projection_fit
// Least-squares surface fit of sample windows by a loaded projection table.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser selects a table word load or a window sample.
// Table words go straight into one RAM bank per coefficient. Samples are
// taken one per cycle; each reads all banks at its window position and
// feeds one multiply-accumulator per coefficient (read, multiply, add).
// Throughput is one beat per cycle, except that a window's last sample can
// be held back as below. The last sample of a window passes the stage 1 and
// stage 2 registers before it reaches the result sequencer; for each
// coefficient that sequencer forms two partial products of the centre
// correction, their sum, a saturating subtract (centred mode), then the
// output beat. A new window streams in meanwhile; only its own last sample
// waits while the previous window is still in the pipeline or being emitted.
// Output stream m_axis: one beat per coefficient, tlast on the final one.
// When the receiver stalls the beat is held and the sequencer waits.
// Reset restores the register defaults and clears the window state; the
// table contents are undefined until loaded.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata.
// ----------------------------------------------------------------------------
module window_surface_projection_fit
    import wsp_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int MAX_COEF   = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CADDR_W-1:0]    i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: table_row[2:0], table_col[10:3], table_word[42:11],
    //        sample_value[74:43], sample_valid[75], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: coef_index[2:0], coef_value[66:3], fit_status[68:67], zero pad
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast
);
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int LW0  = $clog2(MAX_WINDOW + 1);
    localparam int LENW = (LW0 > CFG_W) ? LW0 : CFG_W;

    logic [CFG_W-1:0]  r_window_len;
    logic [ROW_W-1:0]  r_num_coef;
    logic              r_ret_icpt, r_force_ctr;
    logic [AW-1:0]     r_pos;
    t_win_flags        r_flags, n_flags;
    logic              w_busy, w_fin, w_acc, w_samp, w_load, w_end, w_ok;
    logic [LENW-1:0]   w_wlen, w_len, w_pos;
    logic [ROW_W-1:0]  w_nc;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;
    logic signed [SAMP_W-1:0] w_z;
    t_emit_mode        w_mode;
    t_pipe_stat        w_stat;
    logic [MAX_COEF-1:0][ACC_W-1:0]  w_fin_acc;
    logic [MAX_COEF-1:0][RSUM_W-1:0] w_fin_row;

    // field unpacking
    assign w_row = s_axis_tdata[2:0];
    assign w_col = s_axis_tdata[10:3];
    assign w_z   = $signed(s_axis_tdata[74:43]);
    assign w_ok  = s_axis_tdata[75];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= CFG_W'(9);
            r_num_coef   <= ROW_W'(6);
            r_ret_icpt   <= 1'b1;
            r_force_ctr  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW_LEN: r_window_len <= i_cfg_wdata;
                REG_NUM_COEF:   r_num_coef   <= i_cfg_wdata[ROW_W-1:0];
                REG_RET_ICPT:   r_ret_icpt   <= i_cfg_wdata[0];
                REG_FORCE_CTR:  r_force_ctr  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective window length and coefficient count
    assign w_wlen = LENW'(r_window_len);
    assign w_len  = (w_wlen == '0) ? LENW'(1)
                  : (w_wlen > LENW'(MAX_WINDOW)) ? LENW'(MAX_WINDOW) : w_wlen;
    assign w_nc   = (r_num_coef == '0) ? ROW_W'(1)
                  : (r_num_coef > ROW_W'(MAX_COEF)) ? ROW_W'(MAX_COEF) : r_num_coef;
    assign w_mode.nout      = (r_force_ctr || r_ret_icpt) ? w_nc : w_nc - ROW_W'(1);
    assign w_mode.force_ctr = r_force_ctr;
    assign w_mode.ret_icpt  = r_ret_icpt;

    // a window's last sample waits until the previous one is handed over
    assign w_pos  = LENW'(r_pos);
    assign w_end  = (w_pos + LENW'(1) >= w_len);
    assign s_axis_tready = !((s_axis_tuser == CMD_SAMPLE) && w_end
                             && (w_busy || w_stat.s1_end || w_stat.s2_end));
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_samp = w_acc && (s_axis_tuser == CMD_SAMPLE);
    assign w_load = w_acc && (s_axis_tuser == CMD_LOAD) && (w_row < ROW_W'(MAX_COEF))
                    && ({1'b0, w_col} < (COL_W+1)'(MAX_WINDOW > 256 ? 256 : MAX_WINDOW));

    // window summary flags
    always_comb begin
        n_flags = r_flags;
        if (r_pos == '0) n_flags.first = w_z;
        if (w_pos == (w_len >> 1)) n_flags.centre = w_z;
        if (!w_ok) n_flags.missing = 1'b1;
        else if (r_pos != '0 && w_z != r_flags.first) n_flags.all_equal = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '{missing: 1'b0, all_equal: 1'b1, first: '0, centre: '0};
        end else if (w_samp) begin
            if (w_end) begin
                // next window starts from cleared flags
                r_pos   <= '0;
                r_flags <= '{missing: 1'b0, all_equal: 1'b1, first: '0, centre: '0};
            end else begin
                r_pos   <= r_pos + AW'(1);
                r_flags <= n_flags;
            end
        end
    end

    // the summary of a finished window is held until the next window ends
    t_win_flags r_done;
    always_ff @(posedge i_clk) begin
        if (w_samp && w_end) r_done <= n_flags;
    end

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[S_TDATA_W-1:76];

    wsp_mac #(.MAX_WINDOW(MAX_WINDOW), .MAX_COEF(MAX_COEF)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_row     (w_row),
        .i_waddr   (AW'(w_col)),
        .i_word    (s_axis_tdata[42:11]),
        .i_samp    (w_samp),
        .i_raddr   (r_pos),
        .i_z       (w_z),
        .i_ok      (w_ok),
        .i_end     (w_end),
        .o_stat    (w_stat),
        .o_fin     (w_fin),
        .o_fin_acc (w_fin_acc),
        .o_fin_row (w_fin_row)
    );

    wsp_emit #(.MAX_COEF(MAX_COEF)) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fin         (w_fin),
        .i_fin_acc     (w_fin_acc),
        .i_fin_row     (w_fin_row),
        .i_flags       (r_done),
        .i_mode        (w_mode),
        .o_busy        (w_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for window_surface_projection_fit. A behavioural
// surface-fit predictor follows every accepted input beat and queues the
// coefficients it expects; a checker compares each output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import wsp_pkg::*;

    localparam int NWIN = 256;
    localparam int NCOEF = 6;
    localparam int NTAB = 16;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_LEN = 400;
    localparam int SETTLE = 60;

    typedef struct {
        logic [ROW_W-1:0]         idx;
        logic signed [ACC_W-1:0]  val;
        logic [STAT_W-1:0]        st;
        logic                     last;
    } t_coef;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CADDR_W-1:0]     i_cfg_addr;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: table_row, table_col, table_word, sample_value, sample_valid, pad
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    // tuser: command
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: coef_index, coef_value, fit_status, pad
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;

    window_surface_projection_fit dut (.*);

    // predictor state
    logic signed [WORD_W-1:0] proj_mem [NCOEF][NWIN];
    logic signed [ACC_W-1:0]  mac_acc [NCOEF];
    logic signed [ACC_W-1:0]  tbl_sum [NCOEF];
    int unsigned              win_pos;
    logic signed [SAMP_W-1:0] win_first, win_centre;
    bit                       win_flat, win_missing;
    logic [CFG_W-1:0]         r_len;
    logic [2:0]               r_ncoef;
    bit                       r_icpt, r_fctr;

    t_coef coef_expect_q[$];
    int    mismatches = 0;
    int    coefs_seen = 0;
    int    windows_done = 0;
    int    samples_sent = 0;
    bit    calm = 0;
    bit    hold_req = 0;
    int    hold_left = 0;
    int    idle_cycles = 0;

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [ACC_W-1:0] clamp64(logic signed [127:0] w);
        if (&w[127:63] || ~|w[127:63]) return w[63:0];
        return w[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    endfunction

    task automatic clear_win();
        for (int j = 0; j < NCOEF; j++) begin
            mac_acc[j] = 0;
            tbl_sum[j] = 0;
        end
        win_pos = 0;
        win_first = 0;
        win_centre = 0;
        win_flat = 1;
        win_missing = 0;
    endtask

    // surface-fit predictor: one accepted beat in, expected coefficients queued
    task automatic fit_take_beat(logic cmd, logic [S_TDATA_W-1:0] d);
        logic [2:0] row;
        logic [7:0] col;
        logic signed [31:0] z;
        int unsigned len, nc, nout, p;
        logic signed [127:0] w, a, b;
        longint prod;
        t_coef c;
        row = d[2:0];
        col = d[10:3];
        z = d[74:43];
        if (cmd == CMD_LOAD) begin
            if (row < NCOEF) proj_mem[row][col] = d[42:11];
            return;
        end
        len = (r_len == 0) ? 1 : (r_len > NWIN ? NWIN : r_len);
        nc = (r_ncoef == 0) ? 1 : (r_ncoef > NCOEF ? NCOEF : r_ncoef);
        p = (win_pos >= NWIN) ? NWIN - 1 : win_pos;
        if (p == 0) win_first = z;
        if (p == len / 2) win_centre = z;
        if (!d[75]) begin
            win_missing = 1;
        end else begin
            if (p != 0 && z != win_first) win_flat = 0;
            for (int j = 0; j < NCOEF; j++) begin
                prod = longint'(proj_mem[j][p]) * longint'(z);
                w = mac_acc[j];
                w = w + prod;
                mac_acc[j] = clamp64(w);
            end
        end
        for (int j = 0; j < NCOEF; j++) tbl_sum[j] = tbl_sum[j] + proj_mem[j][p];
        if (p + 1 < len) begin
            win_pos = p + 1;
            return;
        end
        nout = (r_fctr || r_icpt) ? nc : nc - 1;
        for (int j = 0; j < nout; j++) begin
            c.idx = ROW_W'(j);
            c.last = (j == nout - 1);
            c.val = 0;
            if (win_missing) begin
                c.st = ST_NODATA;
            end else if (win_flat) begin
                c.st = ST_FLAT;
                if (!r_fctr && r_icpt && j == nout - 1)
                    c.val = longint'(win_first) * 64'sd16777216;
            end else begin
                c.st = ST_FIT;
                if (r_fctr) begin
                    w = mac_acc[j];
                    a = tbl_sum[j];
                    b = win_centre;
                    c.val = clamp64(w - a * b);
                end else begin
                    c.val = mac_acc[j];
                end
            end
            coef_expect_q.push_back(c);
        end
        windows_done++;
        clear_win();
    endtask

    // one input beat, entered and left at a falling edge
    task automatic send_beat(logic cmd, logic [S_TDATA_W-1:0] d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        fit_take_beat(cmd, d);
        if (cmd == CMD_SAMPLE) samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_word(int row, int col, logic [31:0] word);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[2:0] = row;
        d[10:3] = col;
        d[42:11] = word;
        d[74:43] = $urandom;
        d[75] = $urandom_range(0, 1);
        send_beat(CMD_LOAD, d);
    endtask

    task automatic send_sample(logic [31:0] z, bit ok);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[2:0] = $urandom;
        d[10:3] = $urandom;
        d[42:11] = $urandom;
        d[74:43] = z;
        d[75] = ok;
        send_beat(CMD_SAMPLE, d);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic int cur_len();
        return (r_len == 0) ? 1 : (r_len > NWIN ? NWIN : r_len);
    endfunction

    // kind: 0 fitted, 1 flat, 2 with missing samples
    task automatic send_window(int kind);
        logic [31:0] flat_v;
        int n, gap;
        n = cur_len() - win_pos;
        flat_v = rand_sample();
        gap = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
            if (kind == 1) send_sample(flat_v, (k == gap) ? $urandom_range(0, 1) : 1'b1);
            else if (kind == 2) send_sample(rand_sample(), k != gap);
            else send_sample(rand_sample(), 1'b1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (coef_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CADDR_W-1:0] idx, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= CFG_W'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_WINDOW_LEN: r_len = CFG_W'(v);
            REG_NUM_COEF:   r_ncoef = 3'(v);
            REG_RET_ICPT:   r_icpt = v[0];
            REG_FORCE_CTR:  r_fctr = v[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(int len, int nc, bit icpt, bit fctr);
        drain();
        cfg_write(REG_WINDOW_LEN, len);
        cfg_write(REG_NUM_COEF, nc);
        cfg_write(REG_RET_ICPT, icpt);
        cfg_write(REG_FORCE_CTR, fctr);
    endtask

    // table columns used by every window, so no position reads an unwritten entry
    task automatic test_table_load();
        for (int r = 0; r < NCOEF; r++)
            for (int c = 0; c < NTAB; c++)
                load_word(r, c, (c == 0) ? 32'h8000_0000 : (c == 1) ? 32'h7FFF_FFFF :
                          $signed($urandom_range(0, 1 << 26)) - (1 << 25));
        // rows past the last coefficient are dropped
        load_word(6, 0, $urandom);
        load_word(7, 255, $urandom);
    endtask

    // reset defaults: fitted, flat, missing and extreme windows
    task automatic test_directed();
        send_window(0);
        send_window(1);
        send_window(2);
        for (int k = 0; k < 9; k++) send_sample(k[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b1);
    endtask

    task automatic test_modes();
        set_mode(9, 6, 1, 1);
        send_window(0);
        send_window(1);
        set_mode(5, 4, 0, 0);
        send_window(0);
        send_window(1);
        // single coefficient without intercept ends silently
        set_mode(3, 1, 0, 0);
        send_window(0);
        send_window(2);
        set_mode(0, 0, 1, 0);
        send_window(0);
        send_window(1);
        set_mode(1, 7, 0, 1);
        send_window(0);
        // length above the maximum, cut short before leaving the loaded columns
        set_mode(511, 6, 1, 1);
        repeat (2) send_sample(rand_sample(), 1'b1);
        drain();
        cfg_write(REG_WINDOW_LEN, 3);
        send_sample(rand_sample(), 1'b1);
    endtask

    // window length lowered with a window half taken
    task automatic test_shrink();
        set_mode(9, 6, 1, 0);
        repeat (5) send_sample(rand_sample(), 1'b1);
        drain();
        cfg_write(REG_WINDOW_LEN, 3);
        send_sample(rand_sample(), 1'b1);
    endtask

    // receiver holds off while windows keep arriving
    task automatic test_backpressure();
        set_mode(2, 6, 1, 1);
        hold_req = 1;
        repeat (12) send_window(0);
    endtask

    task automatic test_random();
        int kind;
        while (samples_sent < 320) begin
            if (samples_sent > 260) calm = 1;
            set_mode(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) :
                     $urandom_range(1, 12), $urandom_range(0, 7),
                     $urandom_range(0, 1), $urandom_range(0, 1));
            if (cur_len() > NTAB) cfg_write(REG_WINDOW_LEN, $urandom_range(1, 12));
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    load_word($urandom_range(0, 7), $urandom_range(0, 255), $urandom);
                kind = $urandom_range(0, 9);
                send_window(kind < 7 ? 0 : kind < 9 ? 2 : 1);
            end
        end
    endtask

    // receiver readiness
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_coef e;
            coefs_seen++;
            if (coef_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
            end else begin
                e = coef_expect_q.pop_front();
                if (m_axis_tdata[2:0] !== e.idx || m_axis_tdata[66:3] !== e.val ||
                    m_axis_tdata[68:67] !== e.st || m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d val %h st %0d last %0d, got idx %0d val %h st %0d last %0d",
                                 e.idx, e.val, e.st, e.last, m_axis_tdata[2:0],
                                 m_axis_tdata[66:3], m_axis_tdata[68:67], m_axis_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_LOAD;
        m_axis_tready = 0;
        r_len = 9;
        r_ncoef = 6;
        r_icpt = 1;
        r_fctr = 0;
        for (int r = 0; r < NCOEF; r++)
            for (int c = 0; c < NWIN; c++) proj_mem[r][c] = 0;
        clear_win();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        test_table_load();
        test_directed();
        test_modes();
        test_shrink();
        test_backpressure();
        test_random();
        drain();
        $display("covered %0d samples in %0d windows, %0d coefficients checked",
                 samples_sent, windows_done, coefs_seen);
        $display("modes: fitted, flat, missing, centred, no intercept, length limits, stalls");
        if (mismatches == 0 && coef_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     coef_expect_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
